// ===== hdl/dcq_pkg.sv =====
// shared types and constants of the distance ordered candidate queue
// no dependencies; every other file but dcq_ram refers to this package by scoped names
package dcq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 7;
	localparam int ID_W     = 32;
	localparam int DIST_W   = 32;
	localparam int ENTRY_W  = ID_W + DIST_W;

	typedef enum logic [2:0] {
		KIND_PUSH   = 3'd0,
		KIND_POP    = 3'd1,
		KIND_PEEK   = 3'd2,
		KIND_FIND   = 3'd3,
		KIND_UPDATE = 3'd4,
		KIND_CLEAR  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_MISSING = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DEL_RD,
		S_DEL_WR,
		S_DEL_END,
		S_INS_START,
		S_INS_RD,
		S_INS_WR,
		S_INS_PUT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [ID_W-1:0]   id;
	} entry_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] distance;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] distance;
		logic [OCC_W-1:0]  occ;
	} res_t;

endpackage

// ===== hdl/distance_ordered_candidate_queue.sv =====
// top level of the distance ordered candidate queue: request buffer, result register
// depends on dcq_pkg, dcq_ctrl and dcq_ram
//
// Bounded priority queue of up to dcq_pkg::CAPACITY entries (vertex id, distance) held
// sorted by rising distance in one synchronous ram; equal distances keep arrival order.
// Every request gives one result. Work is done one request at a time by a sequencer
// that reads one ram entry, then writes it back, one entry at a time, so the time per
// request follows the number of entries held. Clear, a dropped push and a pop, peek,
// find or update of an empty queue go straight to the result; peek reads the head,
// find scans to a hit or to the end, pop takes the head and closes the gap, push moves
// up the entries above its place, and update scans, closes the gap and reopens it at
// the new place. One request waits in an input buffer while another is worked on,
// and a finished result waits in the output register without blocking the next
// request. No clearing pass after reset: only entries below the count are read.
module distance_ordered_candidate_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // vertex_id[31:0], distance[63:32]
	input  logic [2:0]  s_axis_tuser,  // kind[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // found_id[31:0], found_distance[63:32],
	                                   // occupancy[70:64], zero[71]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	dcq_pkg::cmd_t cmd_q;
	dcq_pkg::res_t res, res_q;
	logic          cmd_full_q, out_full_q;
	logic          cmd_take, res_valid, res_ready;

	assign s_axis_tready = !cmd_full_q;
	assign res_ready     = !out_full_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_full_q <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				cmd_full_q <= 1'b1;
			end else if (cmd_take) begin
				cmd_full_q <= 1'b0;
			end
			if (res_valid && res_ready) begin
				out_full_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_q <= '{kind: s_axis_tuser, id: s_axis_tdata[31:0],
			           distance: s_axis_tdata[63:32]};
		end
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	dcq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_full_q),
		.cmd      (cmd_q),
		.cmd_take (cmd_take),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign m_axis_tvalid = out_full_q;
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tdata  = {1'b0, res_q.occ, res_q.distance, res_q.id};

endmodule

// ===== hdl/dcq_ram.sv =====
// generic simple dual-port ram, one write port, one read port with registered data
// no dependencies
module dcq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/dcq_ctrl.sv =====
// sequencer of the candidate queue: scans, shifts and inserts entries in the sorted ram
// depends on dcq_pkg and dcq_ram
module dcq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  dcq_pkg::cmd_t  cmd,
	output logic           cmd_take,
	output logic           res_valid,
	input  logic           res_ready,
	output dcq_pkg::res_t  res
);

	dcq_pkg::state_t state_q, state_d;
	dcq_pkg::cmd_t   cmd_q;
	dcq_pkg::status_t status_q;
	logic [dcq_pkg::ID_W-1:0]   rid_q;
	logic [dcq_pkg::DIST_W-1:0] rdist_q;
	logic [dcq_pkg::CNT_W-1:0]  count_q;
	logic [dcq_pkg::CNT_W-1:0]  j_q;
	logic [dcq_pkg::CNT_W-1:0]  lim_q;

	logic                       we;
	logic [dcq_pkg::IDX_W-1:0]  waddr;
	logic [dcq_pkg::IDX_W-1:0]  raddr;
	dcq_pkg::entry_t            wdata;
	dcq_pkg::entry_t            rd;
	logic [dcq_pkg::ENTRY_W-1:0] rdata;
	dcq_pkg::entry_t            new_entry;

	logic is_full, is_empty, head_op, hit, last_scan, del_more, del_last, after, kill;

	assign rd        = dcq_pkg::entry_t'(rdata);
	assign new_entry = '{distance: cmd_q.distance, id: cmd_q.id};
	assign is_full   = count_q >= dcq_pkg::CNT_W'(dcq_pkg::CAPACITY);
	assign is_empty  = count_q == '0;
	assign head_op   = (cmd_q.kind == dcq_pkg::KIND_POP) || (cmd_q.kind == dcq_pkg::KIND_PEEK);
	// pop and peek take the head entry without comparing
	assign hit       = head_op || (rd.id == cmd_q.id);
	assign last_scan = j_q == count_q - 1'b1;
	assign del_more  = (j_q + 1'b1) < count_q;
	assign del_last  = j_q == count_q - 1'b1;
	assign kill      = (cmd_q.kind == dcq_pkg::KIND_POP) || (cmd_q.kind == dcq_pkg::KIND_UPDATE);
	// entry stays above the new one: larger distance, or equal and past the old place
	assign after     = (rd.distance > cmd_q.distance) ||
	                   ((rd.distance == cmd_q.distance) && (j_q >= lim_q));

	dcq_ram #(
		.WIDTH(dcq_pkg::ENTRY_W),
		.DEPTH(dcq_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dcq_pkg::S_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						dcq_pkg::KIND_PUSH:
							state_d = is_full ? dcq_pkg::S_DONE : dcq_pkg::S_INS_START;
						dcq_pkg::KIND_POP, dcq_pkg::KIND_PEEK,
						dcq_pkg::KIND_FIND, dcq_pkg::KIND_UPDATE:
							state_d = is_empty ? dcq_pkg::S_DONE : dcq_pkg::S_SCAN_RD;
						default:
							state_d = dcq_pkg::S_DONE;
					endcase
				end
			end
			dcq_pkg::S_SCAN_RD:  state_d = dcq_pkg::S_SCAN_CHK;
			dcq_pkg::S_SCAN_CHK: begin
				if (hit) begin
					if (kill) begin
						state_d = del_more ? dcq_pkg::S_DEL_RD : dcq_pkg::S_DEL_END;
					end else begin
						state_d = dcq_pkg::S_DONE;
					end
				end else begin
					state_d = last_scan ? dcq_pkg::S_DONE : dcq_pkg::S_SCAN_RD;
				end
			end
			dcq_pkg::S_DEL_RD:  state_d = dcq_pkg::S_DEL_WR;
			dcq_pkg::S_DEL_WR:  state_d = del_last ? dcq_pkg::S_DEL_END : dcq_pkg::S_DEL_RD;
			dcq_pkg::S_DEL_END: begin
				state_d = (cmd_q.kind == dcq_pkg::KIND_UPDATE) ? dcq_pkg::S_INS_START
				                                              : dcq_pkg::S_DONE;
			end
			dcq_pkg::S_INS_START: state_d = is_empty ? dcq_pkg::S_INS_PUT : dcq_pkg::S_INS_RD;
			dcq_pkg::S_INS_RD:    state_d = dcq_pkg::S_INS_WR;
			dcq_pkg::S_INS_WR: begin
				if (after) begin
					state_d = (j_q == '0) ? dcq_pkg::S_INS_PUT : dcq_pkg::S_INS_RD;
				end else begin
					state_d = dcq_pkg::S_DONE;
				end
			end
			dcq_pkg::S_INS_PUT: state_d = dcq_pkg::S_DONE;
			dcq_pkg::S_DONE:    state_d = res_ready ? dcq_pkg::S_IDLE : dcq_pkg::S_DONE;
			default:            state_d = dcq_pkg::S_IDLE;
		endcase
	end

	// ram access and handshake outputs
	always_comb begin
		we        = 1'b0;
		waddr     = dcq_pkg::IDX_W'(j_q + 1'b1);
		wdata     = rd;
		raddr     = j_q[dcq_pkg::IDX_W-1:0];
		cmd_take  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			dcq_pkg::S_IDLE: cmd_take = cmd_valid;
			dcq_pkg::S_DEL_WR: begin
				we    = 1'b1;
				waddr = dcq_pkg::IDX_W'(j_q - 1'b1);
			end
			dcq_pkg::S_INS_WR: begin
				we    = 1'b1;
				wdata = after ? rd : new_entry;
			end
			dcq_pkg::S_INS_PUT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = new_entry;
			end
			dcq_pkg::S_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res = '{status: status_q, id: rid_q, distance: rdist_q,
	               occ: dcq_pkg::OCC_W'(count_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcq_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dcq_pkg::S_IDLE && cmd_valid && cmd.kind == dcq_pkg::KIND_CLEAR) begin
				count_q <= '0;
			end else if (state_q == dcq_pkg::S_DEL_END) begin
				count_q <= count_q - 1'b1;
			end else if (state_q == dcq_pkg::S_INS_PUT ||
			             (state_q == dcq_pkg::S_INS_WR && !after)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			dcq_pkg::S_IDLE: begin
				if (cmd_valid) begin
					cmd_q    <= cmd;
					j_q      <= '0;
					lim_q    <= count_q;
					rid_q    <= '0;
					rdist_q  <= '0;
					status_q <= dcq_pkg::STAT_OK;
					unique case (cmd.kind)
						dcq_pkg::KIND_PUSH:
							if (is_full) status_q <= dcq_pkg::STAT_FULL;
						dcq_pkg::KIND_POP, dcq_pkg::KIND_PEEK:
							if (is_empty) status_q <= dcq_pkg::STAT_EMPTY;
						dcq_pkg::KIND_FIND, dcq_pkg::KIND_UPDATE:
							if (is_empty) status_q <= dcq_pkg::STAT_MISSING;
						default: ;
					endcase
				end
			end
			dcq_pkg::S_SCAN_CHK: begin
				j_q <= j_q + 1'b1;
				if (hit) begin
					rid_q   <= rd.id;
					rdist_q <= (cmd_q.kind == dcq_pkg::KIND_UPDATE) ? cmd_q.distance
					                                                : rd.distance;
					lim_q   <= j_q;
				end else if (last_scan) begin
					status_q <= dcq_pkg::STAT_MISSING;
				end
			end
			dcq_pkg::S_DEL_WR:    j_q <= j_q + 1'b1;
			dcq_pkg::S_INS_START: j_q <= count_q - 1'b1;
			dcq_pkg::S_INS_WR:    if (after) j_q <= j_q - 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== hdl/dcq_checker.sv =====
// port-level checks of the candidate queue, attached to the top level by bind
// depends on dcq_pkg and distance_ordered_candidate_queue
module dcq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// the request buffer holds one request
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while one waits");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[70:64] <= 7'(dcq_pkg::CAPACITY))
		else $error("occupancy above capacity");

	// an empty result has no entry and reports an empty queue
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == dcq_pkg::STAT_EMPTY |->
		m_axis_tdata[63:0] == '0 && m_axis_tdata[70:64] == '0)
		else $error("empty status with data or entries");

	// a dropped push only happens at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == dcq_pkg::STAT_FULL |->
		m_axis_tdata[63:0] == '0 && m_axis_tdata[70:64] == 7'(dcq_pkg::CAPACITY))
		else $error("full status below capacity");

endmodule

bind distance_ordered_candidate_queue dcq_checker u_dcq_checker (.*);

// ===== tb/distance_ordered_candidate_queue_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of distance_ordered_candidate_queue: directed then random requests
// a scoreboard class keeps its own sorted copy of the queue and predicts every result
// depends on dcq_pkg and the rtl of the queue
module distance_ordered_candidate_queue_tb;

	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam int DIRECTED_REQUESTS = 24;
	localparam int RANDOM_REQUESTS   = 500;
	localparam int SETTLE_CYCLES     = 6 * dcq_pkg::CAPACITY + 64;
	localparam int HOLD_OFF_CYCLES   = 250;

	typedef struct packed {
		dcq_pkg::status_t           status;
		logic [dcq_pkg::ID_W-1:0]   vertex;
		logic [dcq_pkg::DIST_W-1:0] distance;
		logic [dcq_pkg::OCC_W-1:0]  occupancy;
	} queue_result_t;

	class queue_scoreboard;
		logic [dcq_pkg::ID_W-1:0]   held_ids[dcq_pkg::CAPACITY];
		logic [dcq_pkg::DIST_W-1:0] held_distances[dcq_pkg::CAPACITY];
		int                         held_count = 0;
		queue_result_t              awaited_results[$];
		int                         mismatches = 0;

		task report(string what);
			$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		function int position_of(logic [dcq_pkg::ID_W-1:0] vertex);
			for (int k = 0; k < held_count; k++)
				if (held_ids[k] == vertex)
					return k;
			return -1;
		endfunction

		function void remove_entry(int at);
			for (int k = at; k + 1 < held_count; k++) begin
				held_ids[k]       = held_ids[k + 1];
				held_distances[k] = held_distances[k + 1];
			end
			held_count--;
		endfunction

		function void insert_entry(int at, logic [dcq_pkg::ID_W-1:0] vertex,
				logic [dcq_pkg::DIST_W-1:0] distance);
			for (int k = held_count; k > at; k--) begin
				held_ids[k]       = held_ids[k - 1];
				held_distances[k] = held_distances[k - 1];
			end
			held_ids[at]       = vertex;
			held_distances[at] = distance;
			held_count++;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function logic [dcq_pkg::ID_W-1:0] any_held_id();
			return held_ids[$urandom_range(held_count - 1, 0)];
		endfunction

		function void note_request(logic [2:0] kind, logic [dcq_pkg::ID_W-1:0] vertex,
				logic [dcq_pkg::DIST_W-1:0] distance);
			queue_result_t r;
			int at;
			int slot;
			r = '0;
			r.status = dcq_pkg::STAT_OK;
			case (kind)
			dcq_pkg::KIND_PUSH: begin
				if (held_count >= dcq_pkg::CAPACITY) begin
					r.status = dcq_pkg::STAT_FULL;
				end else begin
					// goes behind every entry of lower or equal distance
					slot = 0;
					while (slot < held_count && held_distances[slot] <= distance)
						slot++;
					insert_entry(slot, vertex, distance);
				end
			end
			dcq_pkg::KIND_POP, dcq_pkg::KIND_PEEK: begin
				if (held_count == 0) begin
					r.status = dcq_pkg::STAT_EMPTY;
				end else begin
					r.vertex   = held_ids[0];
					r.distance = held_distances[0];
					if (kind == dcq_pkg::KIND_POP)
						remove_entry(0);
				end
			end
			dcq_pkg::KIND_FIND: begin
				at = position_of(vertex);
				if (at < 0) begin
					r.status = dcq_pkg::STAT_MISSING;
				end else begin
					r.vertex   = held_ids[at];
					r.distance = held_distances[at];
				end
			end
			dcq_pkg::KIND_UPDATE: begin
				at = position_of(vertex);
				if (at < 0) begin
					r.status = dcq_pkg::STAT_MISSING;
				end else begin
					// stable place: others lower, or equal and ahead of the old spot
					slot = 0;
					for (int k = 0; k < held_count; k++)
						if (k != at && (held_distances[k] < distance ||
								(held_distances[k] == distance && k < at)))
							slot++;
					r.vertex   = vertex;
					r.distance = distance;
					remove_entry(at);
					insert_entry(slot, vertex, distance);
				end
			end
			dcq_pkg::KIND_CLEAR: held_count = 0;
			default: ;
			endcase
			r.occupancy = dcq_pkg::OCC_W'(held_count);
			awaited_results = {awaited_results, r};
		endfunction

		task check_result(logic [1:0] status, logic [dcq_pkg::ID_W-1:0] vertex,
				logic [dcq_pkg::DIST_W-1:0] distance, logic [dcq_pkg::OCC_W-1:0] occupancy);
			queue_result_t want;
			if (awaited_results.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			want = awaited_results[0];
			awaited_results.delete(0);
			if (status !== want.status)
				report($sformatf("status %0d, expected %s", status, want.status.name()));
			if (vertex !== want.vertex)
				report($sformatf("found_id %h, expected %h", vertex, want.vertex));
			if (distance !== want.distance)
				report($sformatf("found_distance %h, expected %h", distance, want.distance));
			if (occupancy !== want.occupancy)
				report($sformatf("occupancy %0d, expected %0d", occupancy, want.occupancy));
		endtask
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata  = '0;
	logic [2:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	queue_scoreboard board = new();
	logic [dcq_pkg::ID_W-1:0] id_pool[16];
	int requests_sent = 0;
	int results_taken = 0;

	distance_ordered_candidate_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly addresses from a small pool so that finds, updates and duplicates hit
	function automatic logic [dcq_pkg::ID_W-1:0] pick_vertex();
		if ($urandom_range(3, 0) != 0)
			return id_pool[$urandom_range(15, 0)];
		return $urandom();
	endfunction

	function automatic logic [dcq_pkg::DIST_W-1:0] pick_distance();
		case ($urandom_range(9, 0))
		0: return '0;
		1: return '1;
		2, 3, 4, 5: return $urandom_range(15, 0);
		6: return 32'hFFFF_FFF0 | $urandom_range(15, 0);
		default: return $urandom();
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_request(logic [2:0] kind, logic [dcq_pkg::ID_W-1:0] vertex,
			logic [dcq_pkg::DIST_W-1:0] distance);
		while (!(requests_sent >= 250 && requests_sent < 350) &&
				$urandom_range(99, 0) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {distance, vertex};
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_request(kind, vertex, distance);
		if (kind <= dcq_pkg::KIND_CLEAR)
			requests_sent++;
		@(negedge clk);
	endtask

	// result side: random stalls, a calm stretch, and two long hold-offs
	initial begin
		int hold_left;
		hold_left = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (results_taken >= 250 && results_taken < 350) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99, 0) >= 11);
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				board.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
					m_axis_tdata[70:64]);
				results_taken++;
				if (results_taken == 60 || results_taken == 420)
					hold_left = HOLD_OFF_CYCLES;
			end
		end
	end

	initial begin
		int pick;
		logic [dcq_pkg::ID_W-1:0] vertex;
		for (int k = 0; k < 16; k++)
			id_pool[k] = $urandom();
		id_pool[0] = '0;
		id_pool[1] = '1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queue
		send_request(dcq_pkg::KIND_PEEK, '1, '1);
		send_request(dcq_pkg::KIND_POP, '0, '0);
		send_request(dcq_pkg::KIND_FIND, '0, '0);
		send_request(dcq_pkg::KIND_UPDATE, '0, 32'd5);
		// extremes, ties and a duplicate address
		send_request(dcq_pkg::KIND_PUSH, '0, '0);
		send_request(dcq_pkg::KIND_PUSH, '1, '1);
		send_request(dcq_pkg::KIND_PUSH, 32'h0000_000A, '0);
		send_request(dcq_pkg::KIND_PUSH, '0, 32'd7);
		send_request(dcq_pkg::KIND_PUSH, 32'h0000_0005, '1);
		send_request(dcq_pkg::KIND_FIND, '0, '1);
		send_request(dcq_pkg::KIND_FIND, '1, '0);
		send_request(dcq_pkg::KIND_FIND, 32'h0001_2345, '0);
		// moves into a run of equal distances
		send_request(dcq_pkg::KIND_UPDATE, 32'h0000_000A, '1);
		send_request(dcq_pkg::KIND_UPDATE, '0, 32'd7);
		send_request(dcq_pkg::KIND_UPDATE, 32'h0000_0005, '0);
		send_request(dcq_pkg::KIND_UPDATE, 32'h0000_0099, 32'd3);
		send_request(dcq_pkg::KIND_PEEK, '0, '0);
		send_request(dcq_pkg::KIND_POP, '1, '1);
		send_request(KIND_SPARE_LO, '1, '1);
		send_request(KIND_SPARE_HI, 32'h5555_5555, 32'hAAAA_AAAA);
		send_request(dcq_pkg::KIND_CLEAR, '1, '1);
		send_request(dcq_pkg::KIND_POP, '0, '0);
		send_request(dcq_pkg::KIND_PUSH, '1, 32'h8000_0000);
		send_request(dcq_pkg::KIND_FIND, '1, '0);

		while (requests_sent < DIRECTED_REQUESTS + RANDOM_REQUESTS) begin
			case ($urandom_range(9, 0))
			0, 1: begin
				// fill to capacity and a little past, so some pushes are dropped
				repeat (dcq_pkg::CAPACITY - board.held_count + $urandom_range(3, 0))
					send_request(dcq_pkg::KIND_PUSH, pick_vertex(), pick_distance());
			end
			2: begin
				repeat (board.held_count + $urandom_range(2, 0))
					send_request(dcq_pkg::KIND_POP, $urandom(), $urandom());
			end
			3: send_request(dcq_pkg::KIND_CLEAR, $urandom(), $urandom());
			default: begin
				repeat (20) begin
					pick = $urandom_range(99, 0);
					vertex = (board.held_count > 0 && $urandom_range(3, 0) != 0) ?
						board.any_held_id() : pick_vertex();
					if (pick < 30)
						send_request(dcq_pkg::KIND_PUSH, pick_vertex(), pick_distance());
					else if (pick < 45)
						send_request(dcq_pkg::KIND_POP, $urandom(), $urandom());
					else if (pick < 55)
						send_request(dcq_pkg::KIND_PEEK, $urandom(), $urandom());
					else if (pick < 70)
						send_request(dcq_pkg::KIND_FIND, vertex, $urandom());
					else if (pick < 94)
						send_request(dcq_pkg::KIND_UPDATE, vertex, pick_distance());
					else if (pick < 96)
						send_request(dcq_pkg::KIND_CLEAR, $urandom(), $urandom());
					else
						send_request(pick[0] ? KIND_SPARE_HI : KIND_SPARE_LO,
							$urandom(), $urandom());
				end
			end
			endcase
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("timeout with %0d results outstanding", board.pending());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/dcq_pkg.sv
hdl/dcq_ram.sv
hdl/dcq_ctrl.sv
hdl/distance_ordered_candidate_queue.sv
hdl/dcq_checker.sv
tb/distance_ordered_candidate_queue_tb.sv
